### hw/rtl/pvm_pkg.sv
// Package for the 24-voice PCM sample playback mixer.
// Holds shared constants, command and status types, and the log expansion function.
// Depends on nothing.
package pvm_pkg;

   localparam int NumVoicesDef = 24;
   localparam int SampleAddrBitsDef = 18;
   localparam int MixW = 29;

   localparam logic [1:0] MODE_REG_WRITE = 2'd0;
   localparam logic [1:0] MODE_LOAD = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   localparam logic [3:0] REG_RVOL = 4'd0;
   localparam logic [3:0] REG_LVOL = 4'd1;
   localparam logic [3:0] REG_PITCH_H = 4'd2;
   localparam logic [3:0] REG_PITCH_L = 4'd3;
   localparam logic [3:0] REG_BANK = 4'd4;
   localparam logic [3:0] REG_CTRL = 4'd5;
   localparam logic [3:0] REG_START_H = 4'd6;
   localparam logic [3:0] REG_START_L = 4'd7;
   localparam logic [3:0] REG_END_H = 4'd8;
   localparam logic [3:0] REG_END_L = 4'd9;
   localparam logic [3:0] REG_LOOP_H = 4'd10;
   localparam logic [3:0] REG_LOOP_L = 4'd11;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic reg_write;   // apply the captured register byte write
      logic load;        // write the captured word into the sample store
      logic clear_acc;   // clear the mix sums and select voice zero
      logic step_init;   // load the working phase and position of the current voice
      logic step;        // run one phase step of the current voice
      logic commit;      // write back phase and position of the current voice
      logic fetch0;      // issue the read of the first sample
      logic fetch1;      // issue the read of the second sample
      logic interp;      // form the interpolation product
      logic scale;       // form the volume products
      logic accum;       // add the products into the sums
      logic next_voice;  // move to the next voice
   } pvm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic voice_live;  // current voice is busy and playing
      logic stopped;     // current voice ran past its end without loop
      logic steps_done;  // step count reached the tick's step count
      logic muted;       // current voice is muted
      logic last_voice;  // current voice is the last one
   } pvm_sts_type;

   // Expands an 8-bit logarithmic code to a signed 16-bit sample.
   function automatic logic signed [15:0] expand_log(input logic [7:0] code);
      logic [2:0] ex;
      logic [15:0] base;
      logic [15:0] shifted;
      ex = code[2:0];
      if (code[7]) begin
         base = ((ex != 3'd0) ? 16'hfe00 : 16'hff00) | {8'd0, code[6:3], 4'd0};
      end else begin
         base = ((ex != 3'd0) ? 16'h0100 : 16'h0000) | {8'd0, code[6:3], 4'd0};
      end
      shifted = (ex != 3'd0) ? (base << (ex - 3'd1)) : base;
      return signed'(shifted);
   endfunction

endpackage

### hw/rtl/pvm_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module pvm_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/pvm_ctrl.sv
// Controller state machine of the PCM mixer.
// Depends on pvm_pkg; drives the datapath through pvm_cmd_type.
module pvm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pvm_pkg::pvm_cmd_type cmd,
   input  pvm_pkg::pvm_sts_type sts
);
   import pvm_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_REG = 4'd1;
   localparam logic [3:0] S_LOAD = 4'd2;
   localparam logic [3:0] S_VINIT = 4'd3;
   localparam logic [3:0] S_STEP = 4'd4;
   localparam logic [3:0] S_FETCH0 = 4'd5;
   localparam logic [3:0] S_FETCH1 = 4'd6;
   localparam logic [3:0] S_INTERP = 4'd8;
   localparam logic [3:0] S_SCALE = 4'd9;
   localparam logic [3:0] S_ACCUM = 4'd10;
   localparam logic [3:0] S_NEXT = 4'd11;
   localparam logic [3:0] S_OUT = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      req_ready = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               priority case (req_mode)
                  MODE_REG_WRITE: state_in = S_REG;
                  MODE_LOAD: state_in = S_LOAD;
                  MODE_TICK: begin
                     cmd.clear_acc = 1'b1;
                     state_in = S_VINIT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_REG: begin
            cmd.reg_write = 1'b1;
            state_in = S_IDLE;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_IDLE;
         end
         S_VINIT: begin
            cmd.step_init = 1'b1;
            state_in = sts.voice_live ? S_STEP : S_NEXT;
         end
         S_STEP: begin
            // One phase step per cycle until the count is reached or the voice stops.
            if (sts.stopped || sts.steps_done) begin
               cmd.commit = 1'b1;
               state_in = (sts.stopped || sts.muted) ? S_NEXT : S_FETCH0;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_FETCH0: begin
            cmd.fetch0 = 1'b1;
            state_in = S_FETCH1;
         end
         S_FETCH1: begin
            // The second word is on the read port during the next cycle.
            cmd.fetch1 = 1'b1;
            state_in = S_INTERP;
         end
         S_INTERP: begin
            cmd.interp = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (sts.last_voice) begin
               state_in = S_OUT;
            end else begin
               cmd.next_voice = 1'b1;
               state_in = S_VINIT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### hw/rtl/pvm_dp.sv
// Datapath of the PCM mixer: voice registers, step unit, sample fetch, mix sums.
// Depends on pvm_pkg and pvm_ram.
module pvm_dp #(
   parameter int NumVoices = pvm_pkg::NumVoicesDef,
   parameter int SampleAddrBits = pvm_pkg::SampleAddrBitsDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_take,
   input  logic [8:0]                   req_reg_address,
   input  logic [7:0]                   req_write_data,
   input  logic [SampleAddrBits-1:0]    req_sample_address,
   input  logic signed [15:0]           req_sample_word,
   input  logic [7:0]                   req_tick_steps,
   input  logic                         csr_take,
   input  logic [23:0]                  csr_mute_mask,
   input  pvm_pkg::pvm_cmd_type         cmd,
   output pvm_pkg::pvm_sts_type         sts,
   input  logic                         rsp_take,
   output logic signed [pvm_pkg::MixW-1:0] rsp_left_mix,
   output logic signed [pvm_pkg::MixW-1:0] rsp_right_mix
);
   import pvm_pkg::*;

   localparam int VW = (NumVoices > 1) ? $clog2(NumVoices) : 1;

   logic [7:0]  rvol_ff [NumVoices];
   logic [7:0]  lvol_ff [NumVoices];
   logic [15:0] pitch_ff [NumVoices];
   logic [7:0]  bank_ff [NumVoices];
   logic [15:0] start_ff [NumVoices];
   logic [15:0] end_ff [NumVoices];
   logic [15:0] loop_ff [NumVoices];
   logic [16:0] pos_ff [NumVoices];
   logic [15:0] frac_ff [NumVoices];
   logic [NumVoices-1:0] comp_ff, loopf_ff, busy_ff, play_ff;
   logic [23:0] mute_ff;

   logic [8:0]  addr_ff;
   logic [7:0]  wdata_ff;
   logic [SampleAddrBits-1:0] saddr_ff;
   logic [15:0] sword_ff;
   logic [7:0]  steps_ff;

   logic [VW-1:0] voice_ff;
   logic [7:0]  cnt_ff;
   logic [15:0] wfrac_ff;
   logic [16:0] wpos_ff;
   logic        stop_ff;
   logic signed [15:0] s1_ff;
   logic signed [31:0] prod_ff;
   logic signed [24:0] lprod_ff, rprod_ff;
   logic signed [MixW-1:0] lsum_ff, rsum_ff, lout_ff, rout_ff;
   logic        rd1_ff;

   // Register write decode.
   logic [4:0] wv;
   logic       wok;
   assign wv = addr_ff[8:4];
   assign wok = (addr_ff < 9'h180) && (32'(wv) < NumVoices);

   always_ff @(posedge clock) begin
      if (req_take) begin
         addr_ff <= req_reg_address;
         wdata_ff <= req_write_data;
         saddr_ff <= req_sample_address;
         sword_ff <= req_sample_word;
         steps_ff <= req_tick_steps;
      end
   end

   // One phase step of the working voice.
   logic [16:0] fsum;
   logic [16:0] npos, wrap_pos;
   logic        past;
   logic [VW-1:0] cv;
   assign cv = voice_ff;
   assign fsum = {1'b0, wfrac_ff} + {1'b0, pitch_ff[cv]};
   assign npos = wpos_ff + 17'd1;
   assign past = npos > {1'b0, end_ff[cv]};
   assign wrap_pos = npos + {1'b0, loop_ff[cv]} - {1'b0, end_ff[cv]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumVoices; i++) begin
            rvol_ff[i] <= '0; lvol_ff[i] <= '0; pitch_ff[i] <= '0; bank_ff[i] <= '0;
            start_ff[i] <= '0; end_ff[i] <= '0; loop_ff[i] <= '0;
            pos_ff[i] <= '0; frac_ff[i] <= '0;
         end
         comp_ff <= '0; loopf_ff <= '0; busy_ff <= '0; play_ff <= '0;
         mute_ff <= '0;
      end else begin
         if (csr_take) begin
            mute_ff <= csr_mute_mask;
         end
         if (cmd.reg_write && wok) begin
            unique case (addr_ff[3:0])
               REG_RVOL: rvol_ff[wv[VW-1:0]] <= wdata_ff;
               REG_LVOL: lvol_ff[wv[VW-1:0]] <= wdata_ff;
               REG_PITCH_H: pitch_ff[wv[VW-1:0]][15:8] <= wdata_ff;
               REG_PITCH_L: pitch_ff[wv[VW-1:0]][7:0] <= wdata_ff;
               REG_BANK: bank_ff[wv[VW-1:0]] <= wdata_ff;
               REG_CTRL: begin
                  comp_ff[wv[VW-1:0]] <= wdata_ff[3];
                  loopf_ff[wv[VW-1:0]] <= wdata_ff[4];
                  busy_ff[wv[VW-1:0]] <= wdata_ff[7];
                  if (wdata_ff[7]) begin
                     play_ff[wv[VW-1:0]] <= 1'b1;
                     frac_ff[wv[VW-1:0]] <= '0;
                     pos_ff[wv[VW-1:0]] <= {1'b0, start_ff[wv[VW-1:0]]};
                  end
               end
               REG_START_H: start_ff[wv[VW-1:0]][15:8] <= wdata_ff;
               REG_START_L: start_ff[wv[VW-1:0]][7:0] <= wdata_ff;
               REG_END_H: end_ff[wv[VW-1:0]][15:8] <= wdata_ff;
               REG_END_L: end_ff[wv[VW-1:0]][7:0] <= wdata_ff;
               REG_LOOP_H: loop_ff[wv[VW-1:0]][15:8] <= wdata_ff;
               REG_LOOP_L: loop_ff[wv[VW-1:0]][7:0] <= wdata_ff;
               default: ;
            endcase
         end
         if (cmd.commit) begin
            pos_ff[cv] <= wpos_ff;
            frac_ff[cv] <= wfrac_ff;
            if (stop_ff) begin
               play_ff[cv] <= 1'b0;
            end
         end
      end
   end

   // Working copy of the current voice during the step loop.
   always_ff @(posedge clock) begin
      if (cmd.clear_acc) begin
         voice_ff <= '0;
      end else if (cmd.next_voice) begin
         voice_ff <= voice_ff + VW'(1);
      end
      if (cmd.step_init) begin
         wfrac_ff <= frac_ff[cv];
         wpos_ff <= pos_ff[cv];
         cnt_ff <= '0;
         stop_ff <= 1'b0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + 8'd1;
         wfrac_ff <= fsum[15:0];
         if (fsum[16]) begin
            if (past && !loopf_ff[cv]) begin
               wpos_ff <= npos;
               stop_ff <= 1'b1;
            end else begin
               wpos_ff <= past ? wrap_pos : npos;
            end
         end
      end
   end

   assign sts.voice_live = busy_ff[cv] && play_ff[cv];
   assign sts.stopped = stop_ff;
   assign sts.steps_done = cnt_ff == steps_ff;
   assign sts.muted = (32'(cv) < 24) ? mute_ff[5'(cv)] : 1'b0;
   assign sts.last_voice = 32'(cv) == NumVoices - 1;

   // Sample store access: loads and the two fetches share the one port.
   logic [SampleAddrBits-1:0] ram_addr;
   logic [15:0] fpos;
   logic [15:0] ram_rd;
   logic [23:0] full_addr;
   assign fpos = cmd.fetch1 ? (wpos_ff[15:0] + 16'd1) : wpos_ff[15:0];
   assign full_addr = {bank_ff[cv], fpos};
   assign ram_addr = cmd.load ? saddr_ff : full_addr[SampleAddrBits-1:0];

   pvm_ram #(.Width(16), .Depth(2 ** SampleAddrBits)) u_store (
      .clock  (clock),
      .wr_en  (cmd.load),
      .addr   (ram_addr),
      .wr_data(sword_ff),
      .rd_data(ram_rd)
   );

   logic signed [15:0] smp_dec;
   always_comb begin
      if (comp_ff[cv]) begin
         smp_dec = expand_log(ram_rd[15:8]);
      end else begin
         smp_dec = signed'({ram_rd[15:4], 4'd0});
      end
   end

   logic signed [16:0] diff;
   logic signed [31:0] mprod;
   logic signed [16:0] sres;
   assign diff = 17'(smp_dec) - 17'(s1_ff);
   assign mprod = 32'(signed'({1'b0, wfrac_ff[15:1]})) * 32'(diff);
   assign sres = 17'(s1_ff) + 17'(prod_ff >>> 15);

   always_ff @(posedge clock) begin
      rd1_ff <= cmd.fetch0;
      if (rd1_ff) begin
         s1_ff <= smp_dec;
      end
      if (cmd.interp) begin
         prod_ff <= mprod;
      end
      if (cmd.scale) begin
         lprod_ff <= 25'(sres) * 25'(signed'({1'b0, lvol_ff[cv]}));
         rprod_ff <= 25'(sres) * 25'(signed'({1'b0, rvol_ff[cv]}));
      end
      if (cmd.clear_acc) begin
         lsum_ff <= '0;
         rsum_ff <= '0;
      end else if (cmd.accum) begin
         lsum_ff <= lsum_ff + MixW'(lprod_ff);
         rsum_ff <= rsum_ff + MixW'(rprod_ff);
      end
      if (sts.last_voice && !cmd.next_voice && !rsp_take) begin
         lout_ff <= lsum_ff;
         rout_ff <= rsum_ff;
      end
   end

   assign rsp_left_mix = lout_ff;
   assign rsp_right_mix = rout_ff;
endmodule

### hw/rtl/pcm_voice_mixer_24ch_top.sv
// Top level of the 24-voice PCM sample playback mixer.
// Depends on pvm_pkg, pvm_ctrl, pvm_dp and pvm_ram.
//
// Channel  Direction  Signals
// req      in         req_valid/req_ready, mode, reg_address, write_data,
//                     sample_address, sample_word, tick_steps
// rsp      out        rsp_valid/rsp_ready, left_mix, right_mix
// csr      in         csr_valid/csr_ready, mute_mask
//
// A register write or sample load passes through one state and returns to idle.
// In a tick, each voice that plays runs its phase steps, the two fetches, interpolation,
// scaling and accumulation; a muted voice or one that stops at its end skips the fetch,
// a voice that does not play skips the steps; the phase step unit does one step per cycle per voice.
// Reset is synchronous and clears all voice registers and control state.
// The result register holds a transfer until taken. New items are accepted
// meanwhile, but a following tick waits at its end until the result is gone.
module pcm_voice_mixer_24ch_top #(
   parameter int NUM_VOICES = pvm_pkg::NumVoicesDef,
   parameter int SAMPLE_ADDR_BITS = pvm_pkg::SampleAddrBitsDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_mode,
   input  logic [8:0]                   req_reg_address,
   input  logic [7:0]                   req_write_data,
   input  logic [SAMPLE_ADDR_BITS-1:0]  req_sample_address,
   input  logic signed [15:0]           req_sample_word,
   input  logic [7:0]                   req_tick_steps,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [pvm_pkg::MixW-1:0] rsp_left_mix,
   output logic signed [pvm_pkg::MixW-1:0] rsp_right_mix,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [23:0]                  csr_mute_mask
);
   import pvm_pkg::*;

   pvm_cmd_type cmd;
   pvm_sts_type sts;

   // The mute mask register is always writable.
   assign csr_ready = 1'b1;

   pvm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode (req_mode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   pvm_dp #(.NumVoices(NUM_VOICES), .SampleAddrBits(SAMPLE_ADDR_BITS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_take          (req_valid && req_ready),
      .req_reg_address   (req_reg_address),
      .req_write_data    (req_write_data),
      .req_sample_address(req_sample_address),
      .req_sample_word   (req_sample_word),
      .req_tick_steps    (req_tick_steps),
      .csr_take          (csr_valid && csr_ready),
      .csr_mute_mask     (csr_mute_mask),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_take          (rsp_valid),
      .rsp_left_mix      (rsp_left_mix),
      .rsp_right_mix     (rsp_right_mix)
   );
endmodule
